// ===== hdl/cbpa_pkg.sv =====
package cbpa_pkg;

  localparam int SIZE_W = 8;
  localparam int ID_W   = 7;
  localparam int ST_W   = 3;

  typedef logic [ST_W-1:0] status_t;

  localparam status_t ST_REUSED       = status_t'(0);
  localparam status_t ST_NEW          = status_t'(1);
  localparam status_t ST_EMPTY        = status_t'(2);
  localparam status_t ST_FULL         = status_t'(3);
  localparam status_t ST_NONE         = status_t'(4);
  localparam status_t ST_RANGE        = status_t'(5);
  localparam status_t ST_NOT_BORROWED = status_t'(6);
  localparam status_t ST_RELEASED     = status_t'(7);

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic              borrowed;
    logic [SIZE_W-1:0] cap;
  } blk_entry_t;

endpackage

// ===== hdl/capacity_block_pool_allocator.sv =====
// Block pool allocator with a first-fit free list.
//
// Input channel: an item (in_op, in_request_size, in_release_id) is taken at a
// rising edge where start is high and busy is low. Acquire (in_op 0) asks for a
// block of in_request_size entries; release (in_op 1) gives block in_release_id
// back. Each item yields exactly one result on out_block_id, out_status and
// out_borrowed_count, shown for a single cycle with out_valid high. The
// receiver cannot hold results off, so the result is always taken then.
// Refused items and acquires with an empty free list are answered in the cycle
// after the accepting edge; a release first reads the block memory in S_REL. An
// acquire over a non-empty free list scans it from the newest entry; on a hit k
// entries behind the newest, the k newer entries then move down one place in
// S_SHIFT. The scan reads the free-list memory and then the block memory, one
// candidate entering per cycle. busy is low in the result cycle, so the next
// item may be taken there. Reset empties the pool and the free list at once; no
// memory sweep is needed.
module capacity_block_pool_allocator #(
  parameter int MAX_BLOCKS  = 64,
  parameter int MAX_REQUEST = 255
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_op,
  input  logic [cbpa_pkg::SIZE_W-1:0]         in_request_size,
  input  logic [cbpa_pkg::ID_W-1:0]           in_release_id,
  output logic                                out_valid,
  output logic [cbpa_pkg::ID_W-1:0]           out_block_id,
  output cbpa_pkg::status_t                   out_status,
  output logic [cbpa_pkg::ID_W-1:0]           out_borrowed_count
);
  import cbpa_pkg::*;

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [1:0] {S_IDLE, S_REL, S_SCAN, S_SHIFT} state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       free_r, free_nxt;
  logic [CW-1:0]       created_r, created_nxt;
  logic [CW-1:0]       rem_r, rem_nxt;
  logic                s1_v_r, s1_v_nxt;
  logic                s2_v_r, s2_v_nxt;
  logic [AW-1:0]       s1_idx_r, s1_idx_nxt;
  logic [AW-1:0]       s2_idx_r, s2_idx_nxt;
  logic [CW-1:0]       s2_cand_r, s2_cand_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [CW-1:0]       rid_r, rid_nxt;
  logic [CW-1:0]       hit_id_r, hit_id_nxt;
  logic [AW-1:0]       sh_wa_r, sh_wa_nxt;

  logic                out_valid_r;
  logic [ID_W-1:0]     out_block_id_r;
  status_t             out_status_r;
  logic [ID_W-1:0]     out_count_r;

  logic                emit;
  logic [CW-1:0]       emit_id;
  status_t             emit_st;
  logic                do_new;
  logic [SIZE_W-1:0]   new_size;
  logic                hit;

  logic [CW-1:0]       fl_mem [MAX_BLOCKS];
  logic                fl_we;
  logic [AW-1:0]       fl_wa;
  logic [CW-1:0]       fl_wd;
  logic [AW-1:0]       fl_ra;
  logic [CW-1:0]       fl_rdata_r;

  blk_entry_t          blk_mem [MAX_BLOCKS];
  logic                blk_we;
  logic [AW-1:0]       blk_wa;
  blk_entry_t          blk_wd;
  logic [AW-1:0]       blk_ra;
  blk_entry_t          blk_rdata_r;

  always_ff @(posedge clk) begin
    if (fl_we) begin
      fl_mem[fl_wa] <= fl_wd;
    end
    fl_rdata_r <= fl_mem[fl_ra];
  end

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[blk_wa] <= blk_wd;
    end
    blk_rdata_r <= blk_mem[blk_ra];
  end

  assign hit = s2_v_r && (s2_cand_r != '0) && (s2_cand_r <= created_r) &&
               (blk_rdata_r.cap >= size_r);

  always_comb begin
    state_nxt   = state_r;
    free_nxt    = free_r;
    created_nxt = created_r;
    rem_nxt     = rem_r;
    s1_v_nxt    = s1_v_r;
    s2_v_nxt    = s2_v_r;
    s1_idx_nxt  = s1_idx_r;
    s2_idx_nxt  = s2_idx_r;
    s2_cand_nxt = s2_cand_r;
    size_nxt    = size_r;
    rid_nxt     = rid_r;
    hit_id_nxt  = hit_id_r;
    sh_wa_nxt   = sh_wa_r;
    emit        = 1'b0;
    emit_id     = '0;
    emit_st     = ST_NONE;
    do_new      = 1'b0;
    new_size    = size_r;
    fl_we       = 1'b0;
    fl_wa       = '0;
    fl_wd       = '0;
    fl_ra       = '0;
    blk_we      = 1'b0;
    blk_wa      = '0;
    blk_wd      = '0;
    blk_ra      = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_op == OP_RELEASE) begin
            if (in_release_id == '0) begin
              emit    = 1'b1;
              emit_st = ST_NONE;
            end else if (32'(in_release_id) > 32'(created_r)) begin
              emit    = 1'b1;
              emit_st = ST_RANGE;
            end else begin
              blk_ra    = AW'(32'(in_release_id) - 32'd1);
              rid_nxt   = CW'(in_release_id);
              state_nxt = S_REL;
            end
          end else begin
            if (in_request_size == '0 || 32'(in_request_size) > MAX_REQUEST) begin
              emit    = 1'b1;
              emit_st = ST_EMPTY;
            end else if (free_r == '0) begin
              do_new   = 1'b1;
              new_size = in_request_size;
            end else begin
              fl_ra      = AW'(32'(free_r) - 32'd1);
              s1_v_nxt   = 1'b1;
              s1_idx_nxt = AW'(32'(free_r) - 32'd1);
              s2_v_nxt   = 1'b0;
              rem_nxt    = free_r - CW'(1);
              size_nxt   = in_request_size;
              state_nxt  = S_SCAN;
            end
          end
        end
      end

      S_REL: begin
        if (blk_rdata_r.borrowed) begin
          blk_we          = 1'b1;
          blk_wa          = AW'(32'(rid_r) - 32'd1);
          blk_wd.borrowed = 1'b0;
          blk_wd.cap      = blk_rdata_r.cap;
          if (32'(free_r) < MAX_BLOCKS) begin
            fl_we    = 1'b1;
            fl_wa    = AW'(free_r);
            fl_wd    = rid_r;
            free_nxt = free_r + CW'(1);
          end
          emit    = 1'b1;
          emit_st = ST_RELEASED;
        end else begin
          emit    = 1'b1;
          emit_st = ST_NOT_BORROWED;
        end
        state_nxt = S_IDLE;
      end

      S_SCAN: begin
        if (hit) begin
          blk_we          = 1'b1;
          blk_wa          = AW'(32'(s2_cand_r) - 32'd1);
          blk_wd.borrowed = 1'b1;
          blk_wd.cap      = blk_rdata_r.cap;
          s1_v_nxt        = 1'b0;
          s2_v_nxt        = 1'b0;
          hit_id_nxt      = s2_cand_r;
          if (32'(s2_idx_r) + 32'd1 == 32'(free_r)) begin
            free_nxt  = free_r - CW'(1);
            emit      = 1'b1;
            emit_id   = s2_cand_r;
            emit_st   = ST_REUSED;
            state_nxt = S_IDLE;
          end else begin
            fl_ra     = AW'(32'(s2_idx_r) + 32'd1);
            sh_wa_nxt = s2_idx_r;
            state_nxt = S_SHIFT;
          end
        end else if (!s1_v_r && !s2_v_r) begin
          do_new   = 1'b1;
          new_size = size_r;
        end else begin
          s2_v_nxt    = s1_v_r;
          s2_idx_nxt  = s1_idx_r;
          s2_cand_nxt = fl_rdata_r;
          blk_ra      = AW'(32'(fl_rdata_r) - 32'd1);
          if (rem_r != '0) begin
            fl_ra      = AW'(32'(rem_r) - 32'd1);
            s1_v_nxt   = 1'b1;
            s1_idx_nxt = AW'(32'(rem_r) - 32'd1);
            rem_nxt    = rem_r - CW'(1);
          end else begin
            s1_v_nxt = 1'b0;
          end
        end
      end

      S_SHIFT: begin
        fl_we = 1'b1;
        fl_wa = sh_wa_r;
        fl_wd = fl_rdata_r;
        if (32'(sh_wa_r) + 32'd2 < 32'(free_r)) begin
          fl_ra     = AW'(32'(sh_wa_r) + 32'd2);
          sh_wa_nxt = AW'(32'(sh_wa_r) + 32'd1);
        end else begin
          free_nxt  = free_r - CW'(1);
          emit      = 1'b1;
          emit_id   = hit_id_r;
          emit_st   = ST_REUSED;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (do_new) begin
      emit      = 1'b1;
      state_nxt = S_IDLE;
      if (32'(created_r) >= MAX_BLOCKS) begin
        emit_st = ST_FULL;
      end else begin
        blk_we          = 1'b1;
        blk_wa          = AW'(created_r);
        blk_wd.borrowed = 1'b1;
        blk_wd.cap      = new_size;
        created_nxt     = created_r + CW'(1);
        emit_id         = created_r + CW'(1);
        emit_st         = ST_NEW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_r      <= '0;
      created_r   <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_r      <= free_nxt;
      created_r   <= created_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= emit;
    end
    rem_r     <= rem_nxt;
    s1_idx_r  <= s1_idx_nxt;
    s2_idx_r  <= s2_idx_nxt;
    s2_cand_r <= s2_cand_nxt;
    size_r    <= size_nxt;
    rid_r     <= rid_nxt;
    hit_id_r  <= hit_id_nxt;
    sh_wa_r   <= sh_wa_nxt;
    if (emit) begin
      out_block_id_r <= ID_W'(emit_id);
      out_status_r   <= emit_st;
      out_count_r    <= ID_W'(created_nxt - free_nxt);
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_block_id       = out_block_id_r;
  assign out_status         = out_status_r;
  assign out_borrowed_count = out_count_r;

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("Result shown while an item is still in work.");

  a_free_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= created_r)
    else $error("Free list holds more blocks than were created.");

  a_new_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_NEW) |-> (out_block_id == ID_W'(created_r)))
    else $error("New block id does not match the created count.");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("Accepted item neither answered nor in work.");

endmodule

// ===== tb/capacity_block_pool_allocator_tb.sv =====
`timescale 1ns / 100ps

module capacity_block_pool_allocator_tb;
  import cbpa_pkg::*;

  localparam int POOL_BLOCKS      = 64;
  localparam int POOL_MAX_REQUEST = 255;
  localparam int RANDOM_ITEMS     = 1550;
  localparam int RUN_LIMIT        = 1000000;

  typedef struct packed {
    logic              op;
    logic [SIZE_W-1:0] size;
    logic [ID_W-1:0]   rid;
    logic              drain;
  } pool_req_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    status_t         st;
    logic [ID_W-1:0] held;
  } outcome_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              in_op = OP_ACQUIRE;
  logic [SIZE_W-1:0] in_request_size = '0;
  logic [ID_W-1:0]   in_release_id = '0;
  logic              busy;
  logic              out_valid;
  logic [ID_W-1:0]   out_block_id;
  status_t           out_status;
  logic [ID_W-1:0]   out_borrowed_count;

  pool_req_t pool_requests[$];
  outcome_t  outcomes_due[$];

  logic [SIZE_W-1:0] blk_cap [1:POOL_BLOCKS];
  bit                blk_out [1:POOL_BLOCKS];
  int                free_ids[$];
  int                created_n = 0;

  int fails = 0;
  int taken_n = 0;
  int sent_n = 0;
  int gap_left = 0;
  int idle_pct = 30;
  int cycles = 0;

  capacity_block_pool_allocator uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_request_size   (in_request_size),
    .in_release_id     (in_release_id),
    .out_valid         (out_valid),
    .out_block_id      (out_block_id),
    .out_status        (out_status),
    .out_borrowed_count(out_borrowed_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic outcome_t pool_outcome(logic op, logic [SIZE_W-1:0] size,
                                            logic [ID_W-1:0] rid);
    outcome_t r;
    int pick;
    r = '0;
    pick = 0;
    if (op == OP_ACQUIRE) begin
      if (size == 0 || int'(size) > POOL_MAX_REQUEST) begin
        r.st = ST_EMPTY;
      end else begin
        for (int i = free_ids.size() - 1; i >= 0 && pick == 0; i--) begin
          if (blk_cap[free_ids[i]] >= size) begin
            pick = free_ids[i];
            free_ids.delete(i);
          end
        end
        if (pick != 0) begin
          r.st = ST_REUSED;
        end else if (created_n < POOL_BLOCKS) begin
          created_n++;
          blk_cap[created_n] = size;
          pick = created_n;
          r.st = ST_NEW;
        end else begin
          r.st = ST_FULL;
        end
        if (pick != 0) begin
          blk_out[pick] = 1'b1;
          r.id = ID_W'(pick);
        end
      end
    end else if (rid == 0) begin
      r.st = ST_NONE;
    end else if (int'(rid) > created_n) begin
      r.st = ST_RANGE;
    end else if (!blk_out[rid]) begin
      r.st = ST_NOT_BORROWED;
    end else begin
      blk_out[rid] = 1'b0;
      free_ids = {free_ids, int'(rid)};
      r.st = ST_RELEASED;
    end
    r.held = ID_W'(created_n - free_ids.size());
    return r;
  endfunction

  task automatic queue_request(logic op, int size, int rid, logic drain);
    pool_req_t req;
    req.op = op;
    req.size = SIZE_W'(size);
    req.rid = ID_W'(rid);
    req.drain = drain;
    pool_requests = {pool_requests, req};
  endtask

  // The driver drops start only after an item was taken, so a pending item is never withdrawn.
  always @(negedge clk) begin
    logic raise;
    pool_req_t nxt;
    raise = 1'b0;
    nxt = '0;
    if (taken_n != sent_n) begin
      void'(pool_requests.pop_front());
      sent_n++;
      if ($urandom_range(0, 99) < idle_pct) begin
        gap_left = $urandom_range(1, 16);
      end
    end
    if (gap_left != 0) begin
      gap_left--;
    end else if (rst_n && pool_requests.size() != 0) begin
      nxt = pool_requests[0];
      if (!nxt.drain || outcomes_due.size() == 0) begin
        raise = 1'b1;
      end
    end
    start <= raise;
    in_op <= nxt.op;
    in_request_size <= nxt.size;
    in_release_id <= nxt.rid;
  end

  always @(posedge clk) begin
    outcome_t due;
    outcome_t got;
    outcome_t fresh;
    if (rst_n && out_valid) begin
      got.id = out_block_id;
      got.st = out_status;
      got.held = out_borrowed_count;
      if (outcomes_due.size() == 0) begin
        $display("%0t: unexpected result: block_id %0d status %0d borrowed_count %0d",
                 $time, got.id, got.st, got.held);
        fails++;
      end else begin
        due = outcomes_due.pop_front();
        if (got.id !== due.id) begin
          $display("%0t: block_id expected %0d actual %0d", $time, due.id, got.id);
          fails++;
        end
        if (got.st !== due.st) begin
          $display("%0t: status expected %0d actual %0d", $time, due.st, got.st);
          fails++;
        end
        if (got.held !== due.held) begin
          $display("%0t: borrowed_count expected %0d actual %0d", $time, due.held, got.held);
          fails++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      fresh = pool_outcome(in_op, in_request_size, in_release_id);
      outcomes_due = {outcomes_due, fresh};
      taken_n++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int made;
    int acq_pct;
    int r;
    int size;
    int rid;
    int held_ids[$];

    queue_request(OP_ACQUIRE, 0, 127, 1'b0);
    queue_request(OP_ACQUIRE, 255, 0, 1'b0);
    queue_request(OP_ACQUIRE, 1, 127, 1'b0);
    queue_request(OP_ACQUIRE, 128, 85, 1'b0);
    queue_request(OP_RELEASE, 255, 0, 1'b0);
    queue_request(OP_RELEASE, 0, 127, 1'b0);
    queue_request(OP_RELEASE, 170, 4, 1'b0);
    queue_request(OP_RELEASE, 85, 2, 1'b0);
    queue_request(OP_RELEASE, 0, 2, 1'b0);
    queue_request(OP_ACQUIRE, 1, 42, 1'b0);
    queue_request(OP_RELEASE, 255, 1, 1'b0);
    queue_request(OP_RELEASE, 0, 3, 1'b0);
    // The newest free block is too small, so the older one is taken and the newer entry moves down.
    queue_request(OP_ACQUIRE, 200, 0, 1'b1);
    queue_request(OP_ACQUIRE, 129, 0, 1'b0);
    queue_request(OP_ACQUIRE, 128, 0, 1'b0);
    queue_request(OP_RELEASE, 0, 64, 1'b0);
    queue_request(OP_RELEASE, 0, 65, 1'b0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    made = 0;
    acq_pct = 85;
    while (made < RANDOM_ITEMS) begin
      if (pool_requests.size() >= 4) begin
        @(posedge clk);
      end else begin
        if (made % 50 == 0) begin
          r = $urandom_range(0, 2);
          acq_pct = (r == 0) ? 85 : (r == 1) ? 55 : 25;
          if (made >= RANDOM_ITEMS - 200 || $urandom_range(0, 3) == 0) begin
            idle_pct = 0;
          end else begin
            idle_pct = 30;
          end
        end
        if ($urandom_range(0, 99) < acq_pct) begin
          r = $urandom_range(0, 99);
          if (r < 5) begin
            size = 0;
          end else if (r < 10) begin
            size = 255;
          end else if (r < 60) begin
            size = $urandom_range(1, 16);
          end else if (r < 80) begin
            size = $urandom_range(1, 64);
          end else begin
            size = $urandom_range(1, 255);
          end
          queue_request(OP_ACQUIRE, size, $urandom_range(0, 127),
                        $urandom_range(0, 99) == 0);
        end else begin
          held_ids.delete();
          for (int i = 1; i <= created_n; i++) begin
            if (blk_out[i]) begin
              held_ids = {held_ids, i};
            end
          end
          r = $urandom_range(0, 99);
          if (r < 75 && held_ids.size() != 0) begin
            rid = held_ids[$urandom_range(0, held_ids.size() - 1)];
          end else if (r < 82) begin
            rid = 0;
          end else if (r < 90) begin
            rid = $urandom_range(1, (created_n > 0) ? created_n : 1);
          end else begin
            rid = $urandom_range(0, 127);
          end
          queue_request(OP_RELEASE, $urandom_range(0, 255), rid,
                        $urandom_range(0, 99) == 0);
        end
        made++;
      end
    end

    while (pool_requests.size() != 0 || outcomes_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (300) @(posedge clk);

    if (fails == 0 && outcomes_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== capacity_block_pool_allocator.f =====
hdl/cbpa_pkg.sv
hdl/capacity_block_pool_allocator.sv
tb/capacity_block_pool_allocator_tb.sv
